// ----- hw/rtl/rar_pkg.sv -----
// Shared types, constants and command/status structs for the fraction arithmetic block.
package rar_pkg;

	// Default operand width used by the top level.
	localparam int OPERAND_WIDTH_DEF = 31;

	// Field widths of the stream payloads.
	localparam int FIELD_W = 31;
	localparam int MODE_W  = 2;
	localparam int MAG_W   = 64;
	localparam int DEN_W   = 63;

	// Input tdata layout, lowest field first.
	localparam int S_TDATA_W = 128;
	localparam int FN_LSB    = MODE_W;
	localparam int FD_LSB    = FN_LSB + FIELD_W;
	localparam int SN_LSB    = FD_LSB + FIELD_W;
	localparam int SD_LSB    = SN_LSB + FIELD_W;

	// Output tdata layout: numerator, then denominator, then zero fill.
	localparam int M_TDATA_W = 128;
	localparam int M_PAD_W   = M_TDATA_W - MAG_W - DEN_W;

	// Operation codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_ADD = 2'd0,
		MODE_MUL = 2'd1,
		MODE_DIV = 2'd2
	} mode_t;

	// Multiplier operand selection.
	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_AC   = 3'd1,
		MUL_BD   = 3'd2,
		MUL_AT1  = 3'd3,
		MUL_CT2  = 3'd4,
		MUL_BT1  = 3'd5
	} mul_sel_t;

	// Numerator register update.
	typedef enum logic [1:0] {
		NUM_HOLD = 2'd0,
		NUM_PROD = 2'd1,
		NUM_ACC  = 2'd2,
		NUM_RED  = 2'd3
	} num_op_t;

	// Denominator register update.
	typedef enum logic [1:0] {
		DEN_HOLD = 2'd0,
		DEN_PROD = 2'd1,
		DEN_ONE  = 2'd2,
		DEN_RED  = 2'd3
	} den_op_t;

	// Binary GCD unit operations.
	typedef enum logic [2:0] {
		GCD_HOLD    = 3'd0,
		GCD_LOAD_BD = 3'd1,
		GCD_LOAD_ND = 3'd2,
		GCD_HALVE   = 3'd3,
		GCD_STEP    = 3'd4,
		GCD_DOUBLE  = 3'd5
	} gcd_op_t;

	// Two-lane restoring divider operations.
	typedef enum logic [1:0] {
		DIV_HOLD  = 2'd0,
		DIV_SHORT = 2'd1,
		DIV_LONG  = 2'd2,
		DIV_STEP  = 2'd3
	} div_op_t;

	// Command word from the controller to the datapath.
	typedef struct packed {
		logic     load;
		mul_sel_t mul_sel;
		num_op_t  num_op;
		den_op_t  den_op;
		gcd_op_t  gcd_op;
		div_op_t  div_op;
		logic     take_t;
		logic     out_load;
	} dp_cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic err;
		logic is_add;
		logic both_even;
		logic gcd_eq;
		logic k_zero;
		logic div_done;
		logic num_zero;
	} dp_status_t;

endpackage

// ----- hw/rtl/rational_arith_reduce_top.sv -----
// Top level of the fraction arithmetic block with reduction to lowest terms.
//
// Input stream (s_*): one transaction carries an operation code and two signed
// fractions. Output stream (m_*): one transaction per input with the reduced
// numerator, the positive reduced denominator and an error flag in tuser.
// Errors (zero denominator, zero divisor, unused operation code) give 0/1.
//
// Latency is data dependent. An error result goes from dispatch straight to
// the output register. Multiply and divide form the two products, run the
// binary GCD loop on the product, restore the common factors of two and divide
// numerator and denominator by the GCD; add first runs the same GCD on the two
// denominators, divides both by it and forms three products, then the same
// reduction. The GCD loop (one halving or subtraction per cycle) and the
// two-lane divider set the latency.
// One item is processed at a time; s_tready is high only while the block is
// idle. A finished result sits in the output register until taken, and the
// next input is accepted meanwhile; a stalled receiver holds the block only
// when the following result is ready to be written.
// Reset clears the controller and the output valid; no clearing pass is needed.
module rational_arith_reduce_top #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// mode[1:0], first_num[32:2], first_den[63:33], second_num[94:64],
	// second_den[125:95], zero fill
	input  logic [rar_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_num[63:0], result_den[126:64], zero fill
	output logic [rar_pkg::M_TDATA_W-1:0] m_tdata,
	// error[0]
	output logic                          m_tuser
);

	rar_pkg::dp_cmd_t    cmd;
	rar_pkg::dp_status_t status;

	// Sequencer.
	rar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and result register.
	rar_dpath #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dpath (
		.clk     (clk),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.status  (status),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// ----- hw/rtl/rar_dpath.sv -----
// Datapath: operand registers, multiplier, binary GCD unit, two-lane divider, output register.
module rar_dpath #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic [rar_pkg::S_TDATA_W-1:0]       s_tdata,
	input  rar_pkg::dp_cmd_t                    cmd,
	output rar_pkg::dp_status_t                 status,
	output logic [rar_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tuser
);

	localparam int W        = OPERAND_WIDTH;
	localparam int OPW      = W + 1;
	localparam int MW       = rar_pkg::MAG_W;
	localparam int CNT_W    = $clog2(2 * W + 1);
	localparam int SHORT_SH = MW - W;
	localparam int LONG_SH  = MW - 2 * W;

	// Input fields, sign-extended from the operand width.
	logic [rar_pkg::MODE_W-1:0] in_mode;
	logic signed [OPW-1:0]      in_a, in_b, in_c, in_d;
	assign in_mode = s_tdata[rar_pkg::MODE_W-1:0];
	assign in_a = {s_tdata[rar_pkg::FN_LSB+W-1], s_tdata[rar_pkg::FN_LSB +: W]};
	assign in_b = {s_tdata[rar_pkg::FD_LSB+W-1], s_tdata[rar_pkg::FD_LSB +: W]};
	assign in_c = {s_tdata[rar_pkg::SN_LSB+W-1], s_tdata[rar_pkg::SN_LSB +: W]};
	assign in_d = {s_tdata[rar_pkg::SD_LSB+W-1], s_tdata[rar_pkg::SD_LSB +: W]};

	// Denominators made positive; a quotient becomes a product with the divisor flipped.
	logic signed [OPW-1:0] an, bn, cn, dn, ce, de;
	logic                  in_err, in_div;
	assign an     = in_b[OPW-1] ? -in_a : in_a;
	assign bn     = in_b[OPW-1] ? -in_b : in_b;
	assign cn     = in_d[OPW-1] ? -in_c : in_c;
	assign dn     = in_d[OPW-1] ? -in_d : in_d;
	assign in_div = (in_mode == rar_pkg::MODE_DIV);
	assign ce     = !in_div ? cn : (cn[OPW-1] ? -dn : dn);
	assign de     = !in_div ? dn : (cn[OPW-1] ? -cn : cn);
	assign in_err = (in_b == '0) || (in_d == '0) || (in_div && in_c == '0) ||
		((in_mode != rar_pkg::MODE_ADD) && (in_mode != rar_pkg::MODE_MUL) && !in_div);

	// Operand and result registers.
	logic signed [OPW-1:0] a_q, b_q, c_q, d_q, t1_q, t2_q;
	logic signed [MW-1:0]  prod_q, num_q;
	logic [MW-1:0]         den_q;
	logic                  err_q, is_add_q, neg_q;

	// GCD unit registers.
	logic [MW-1:0]    x_q, y_q;
	logic [CNT_W-1:0] k_q;
	logic [MW:0]      gdiff;
	assign gdiff = {1'b0, x_q} - {1'b0, y_q};

	// Divider registers; the divisor is the GCD held in x_q.
	logic [MW-1:0]    dvd0_q, dvd1_q, rem0_q, rem1_q, quo0_q, quo1_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW:0]      step0, step1;

	// Output register.
	logic [MW-1:0]             out_num_q;
	logic [rar_pkg::DEN_W-1:0] out_den_q;
	logic                      out_err_q;

	// One restoring division step: quotient bit on top, new remainder below.
	function automatic logic [MW:0] div_step(input logic [MW-1:0] rem,
		input logic msb, input logic [MW-1:0] dsr);
		logic [MW-1:0] t;
		logic [MW:0]   s;
		t = {rem[MW-2:0], msb};
		s = {1'b0, t} - {1'b0, dsr};
		div_step = s[MW] ? {1'b0, t} : {1'b1, s[MW-1:0]};
	endfunction

	// Magnitude of a signed numerator.
	function automatic logic [MW-1:0] x_load_mag(input logic signed [MW-1:0] v);
		x_load_mag = v[MW-1] ? -v : v;
	endfunction

	assign step0 = div_step(rem0_q, dvd0_q[MW-1], x_q);
	assign step1 = div_step(rem1_q, dvd1_q[MW-1], x_q);

	// Multiplier operand selection.
	logic signed [OPW-1:0]   mul_a, mul_b;
	logic signed [2*OPW-1:0] mul_p;
	always_comb begin
		unique case (cmd.mul_sel)
			rar_pkg::MUL_AC:  begin mul_a = a_q; mul_b = c_q;  end
			rar_pkg::MUL_BD:  begin mul_a = b_q; mul_b = d_q;  end
			rar_pkg::MUL_AT1: begin mul_a = a_q; mul_b = t1_q; end
			rar_pkg::MUL_CT2: begin mul_a = c_q; mul_b = t2_q; end
			rar_pkg::MUL_BT1: begin mul_a = b_q; mul_b = t1_q; end
			default:          begin mul_a = '0;  mul_b = '0;   end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Operand capture and multiplier output register.
	always_ff @(posedge clk) begin
		prod_q <= MW'(mul_p);
		if (cmd.load) begin
			a_q      <= an;
			b_q      <= bn;
			c_q      <= ce;
			d_q      <= de;
			err_q    <= in_err;
			is_add_q <= (in_mode == rar_pkg::MODE_ADD);
		end
		if (cmd.take_t) begin
			t1_q <= quo0_q[OPW-1:0];
			t2_q <= quo1_q[OPW-1:0];
		end
	end

	// Numerator and denominator registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= '0;
			den_q <= MW'(1);
		end else begin
			unique case (cmd.num_op)
				rar_pkg::NUM_PROD: num_q <= prod_q;
				rar_pkg::NUM_ACC:  num_q <= num_q + prod_q;
				rar_pkg::NUM_RED:  num_q <= neg_q ? -$signed(quo0_q) : $signed(quo0_q);
				default:           num_q <= num_q;
			endcase
			unique case (cmd.den_op)
				rar_pkg::DEN_PROD: den_q <= prod_q;
				rar_pkg::DEN_ONE:  den_q <= MW'(1);
				rar_pkg::DEN_RED:  den_q <= quo1_q;
				default:           den_q <= den_q;
			endcase
		end
	end

	// Binary GCD: strip common twos, reduce by halving and subtracting, restore twos.
	always_ff @(posedge clk) begin
		unique case (cmd.gcd_op)
			rar_pkg::GCD_LOAD_BD: begin
				x_q <= {{(MW-OPW){1'b0}}, b_q};
				y_q <= {{(MW-OPW){1'b0}}, d_q};
				k_q <= '0;
			end
			rar_pkg::GCD_LOAD_ND: begin
				x_q   <= num_q[MW-1] ? -num_q : num_q;
				y_q   <= den_q;
				neg_q <= num_q[MW-1];
				k_q   <= '0;
			end
			rar_pkg::GCD_HALVE: begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end
			rar_pkg::GCD_STEP: begin
				priority if (x_q == y_q) begin
					x_q <= x_q;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (!gdiff[MW]) begin
					x_q <= gdiff[MW-1:0];
				end else begin
					y_q <= y_q - x_q;
				end
			end
			rar_pkg::GCD_DOUBLE: begin
				x_q <= x_q << 1;
				k_q <= k_q - 1'b1;
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	// Two dividends divided by the same GCD, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		unique case (cmd.div_op)
			rar_pkg::DIV_SHORT: begin
				dvd0_q <= {{(MW-OPW){1'b0}}, d_q} << SHORT_SH;
				dvd1_q <= {{(MW-OPW){1'b0}}, b_q} << SHORT_SH;
				rem0_q <= '0;
				rem1_q <= '0;
				quo0_q <= '0;
				quo1_q <= '0;
				cnt_q  <= CNT_W'(W);
			end
			rar_pkg::DIV_LONG: begin
				dvd0_q <= x_load_mag(num_q) << LONG_SH;
				dvd1_q <= den_q << LONG_SH;
				rem0_q <= '0;
				rem1_q <= '0;
				quo0_q <= '0;
				quo1_q <= '0;
				cnt_q  <= CNT_W'(2 * W);
			end
			rar_pkg::DIV_STEP: begin
				dvd0_q <= dvd0_q << 1;
				dvd1_q <= dvd1_q << 1;
				rem0_q <= step0[MW-1:0];
				rem1_q <= step1[MW-1:0];
				quo0_q <= {quo0_q[MW-2:0], step0[MW]};
				quo1_q <= {quo1_q[MW-2:0], step1[MW]};
				cnt_q  <= cnt_q - 1'b1;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Output register, loaded when the result transaction is presented.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_num_q <= num_q;
			out_den_q <= den_q[rar_pkg::DEN_W-1:0];
			out_err_q <= err_q;
		end
	end

	assign m_tdata = {{rar_pkg::M_PAD_W{1'b0}}, out_den_q, out_num_q};
	assign m_tuser = out_err_q;

	// Status back to the controller.
	always_comb begin
		status.err       = err_q;
		status.is_add    = is_add_q;
		status.both_even = !x_q[0] && !y_q[0];
		status.gcd_eq    = (x_q == y_q);
		status.k_zero    = (k_q == '0);
		status.div_done  = (cnt_q == '0);
		status.num_zero  = (num_q == '0);
	end

endmodule

// ----- hw/rtl/rar_ctrl.sv -----
// Controller: sequences loading, products, GCD, division and the output handshake.
module rar_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  rar_pkg::dp_status_t status,
	output rar_pkg::dp_cmd_t    cmd
);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_DISP  = 13'b0000000000010,
		ST_MUL2  = 13'b0000000000100,
		ST_DEN   = 13'b0000000001000,
		ST_ZCHK  = 13'b0000000010000,
		ST_STRIP = 13'b0000000100000,
		ST_LOOP  = 13'b0000001000000,
		ST_UNSH  = 13'b0000010000000,
		ST_DIV   = 13'b0000100000000,
		ST_MULA  = 13'b0001000000000,
		ST_MULB  = 13'b0010000000000,
		ST_MULC  = 13'b0100000000000,
		ST_OUT   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   final_q, final_d;
	logic   m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		final_d = final_q;
		cmd     = '{load: 1'b0, mul_sel: rar_pkg::MUL_NONE, num_op: rar_pkg::NUM_HOLD,
			den_op: rar_pkg::DEN_HOLD, gcd_op: rar_pkg::GCD_HOLD,
			div_op: rar_pkg::DIV_HOLD, take_t: 1'b0, out_load: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				final_d = 1'b0;
				priority if (status.err) begin
					state_d = ST_OUT;
				end else if (status.is_add) begin
					cmd.gcd_op = rar_pkg::GCD_LOAD_BD;
					state_d    = ST_STRIP;
				end else begin
					cmd.mul_sel = rar_pkg::MUL_AC;
					state_d     = ST_MUL2;
				end
			end
			ST_MUL2: begin
				cmd.mul_sel = rar_pkg::MUL_BD;
				cmd.num_op  = rar_pkg::NUM_PROD;
				state_d     = ST_DEN;
			end
			ST_DEN: begin
				cmd.den_op = rar_pkg::DEN_PROD;
				state_d    = ST_ZCHK;
			end
			ST_ZCHK: begin
				if (status.num_zero) begin
					cmd.den_op = rar_pkg::DEN_ONE;
					state_d    = ST_OUT;
				end else begin
					cmd.gcd_op = rar_pkg::GCD_LOAD_ND;
					final_d    = 1'b1;
					state_d    = ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (status.both_even) begin
					cmd.gcd_op = rar_pkg::GCD_HALVE;
				end else begin
					cmd.gcd_op = rar_pkg::GCD_STEP;
					state_d    = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (status.gcd_eq) begin
					state_d = ST_UNSH;
				end else begin
					cmd.gcd_op = rar_pkg::GCD_STEP;
				end
			end
			ST_UNSH: begin
				if (status.k_zero) begin
					cmd.div_op = final_q ? rar_pkg::DIV_LONG : rar_pkg::DIV_SHORT;
					state_d    = ST_DIV;
				end else begin
					cmd.gcd_op = rar_pkg::GCD_DOUBLE;
				end
			end
			ST_DIV: begin
				if (!status.div_done) begin
					cmd.div_op = rar_pkg::DIV_STEP;
				end else if (final_q) begin
					cmd.num_op = rar_pkg::NUM_RED;
					cmd.den_op = rar_pkg::DEN_RED;
					state_d    = ST_OUT;
				end else begin
					cmd.take_t = 1'b1;
					state_d    = ST_MULA;
				end
			end
			ST_MULA: begin
				cmd.mul_sel = rar_pkg::MUL_AT1;
				state_d     = ST_MULB;
			end
			ST_MULB: begin
				cmd.mul_sel = rar_pkg::MUL_CT2;
				cmd.num_op  = rar_pkg::NUM_PROD;
				state_d     = ST_MULC;
			end
			ST_MULC: begin
				cmd.mul_sel = rar_pkg::MUL_BT1;
				cmd.num_op  = rar_pkg::NUM_ACC;
				state_d     = ST_DEN;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, phase flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			final_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule
